// File: hw/rtl/hlt_pkg.sv
// Shared constants, codes and types of the handle list table.
package hlt_pkg;

  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 32;

  // Port widths fixed by the interface.
  localparam int IN_HANDLE_W = 32;
  localparam int POS_W       = 6;
  localparam int COUNT_W     = 7;

  // Stored key width: low HANDLE_BITS bits of the handle port.
  localparam int KEY_W = (HANDLE_BITS < IN_HANDLE_W) ? HANDLE_BITS : IN_HANDLE_W;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef logic [1:0]       action_t;
  typedef logic [1:0]       status_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam action_t ACT_ADD    = 2'd0;
  localparam action_t ACT_REMOVE = 2'd1;
  localparam action_t ACT_LOOKUP = 2'd2;
  localparam action_t ACT_CLEAR  = 2'd3;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_MISSING = 2'd2;

endpackage

// File: hw/rtl/handle_list_table_unit.sv
// Handle list table: compact list of handles with add, remove, lookup and clear.
//
// The block keeps up to CAPACITY handles packed in insertion order in one
// single-port-write, registered-read memory, plus a fill count. Each input
// word yields exactly one result word. Add and clear go from acceptance
// straight to the done state, which loads the output register. Lookup walks
// the memory one entry per cycle from the bottom and stops at the first match
// or at the last filled entry. Remove does the same walk up to the first match
// and then moves every later entry down one place, one read and one write per
// cycle through the memory port.
// One operation is in flight at a time; the result sits in an output register,
// so the next word is taken while an earlier result still waits for out_ready.
// Entries at or above the fill count never affect a result, so the memory
// needs no clearing after reset. Only the low HANDLE_BITS bits of a handle are
// stored and compared.
module handle_list_table_unit
  import hlt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_action,
  input  logic [IN_HANDLE_W-1:0] in_handle,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output logic                   out_found,
  output logic [POS_W-1:0]       out_position,
  output logic [COUNT_W-1:0]     out_entry_count
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]   state_r, state_nxt;
  cnt_t         fill_r, fill_nxt;
  idx_t         ptr_r, ptr_nxt;          // entry whose data sits in mem_rdata_r while searching
  action_t      act_r, act_nxt;
  key_t         key_r, key_nxt;

  status_t      res_status_r, res_status_nxt;
  logic         res_found_r, res_found_nxt;
  idx_t         res_pos_r, res_pos_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic               out_found_r, out_found_nxt;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  // List storage.
  key_t mem [CAPACITY];
  key_t mem_rdata_r;
  logic mem_we;
  idx_t mem_waddr;
  key_t mem_wdata;
  idx_t mem_raddr;

  logic in_fire;
  key_t in_key;
  cnt_t ptr_ext_inc;

  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign in_key      = in_handle[KEY_W-1:0];
  assign ptr_ext_inc = CNT_W'(ptr_r) + CNT_W'(1);

  // Read address runs one entry ahead in the search and two ahead in the
  // shift, so the next entry is already registered when it is needed.
  always_comb begin
    case (state_r)
      S_SEARCH: mem_raddr = ptr_r + IDX_W'(1);
      S_SHIFT:  mem_raddr = ptr_r + IDX_W'(2);
      default:  mem_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    ptr_nxt        = ptr_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r;
    mem_wdata      = mem_rdata_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt        = in_action;
          key_nxt        = in_key;
          ptr_nxt        = '0;
          res_status_nxt = ST_OK;
          res_found_nxt  = 1'b0;
          res_pos_nxt    = '0;
          state_nxt      = S_DONE;
          case (in_action) inside
            ACT_ADD: begin
              if (fill_r == CNT_W'(CAPACITY)) begin
                // Drop the handle; the list is full.
                res_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = fill_r[IDX_W-1:0];
                mem_wdata = in_key;
                fill_nxt  = fill_r + CNT_W'(1);
              end
            end
            ACT_REMOVE, ACT_LOOKUP: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_MISSING;
              end else begin
                // Entry zero is read this cycle.
                state_nxt = S_SEARCH;
              end
            end
            default: begin
              fill_nxt = '0;
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (mem_rdata_r == key_r) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = ptr_r;
          state_nxt     = (act_r == ACT_REMOVE) ? S_SHIFT : S_DONE;
        end else if (ptr_ext_inc == fill_r) begin
          res_status_nxt = ST_MISSING;
          state_nxt      = S_DONE;
        end else begin
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end

      S_SHIFT: begin
        // mem_rdata_r holds the entry just above ptr_r.
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        if (ptr_ext_inc < fill_r) begin
          mem_wdata = mem_rdata_r;
          ptr_nxt   = ptr_r + IDX_W'(1);
        end else begin
          // Zero the freed top slot and shrink the list.
          mem_wdata = '0;
          fill_nxt  = fill_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_pos_nxt    = POS_W'(res_pos_r);
          out_count_nxt  = COUNT_W'(fill_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers: no reset needed.
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_position    = out_pos_r;
  assign out_entry_count = out_count_r;

endmodule

// File: verif/hlt_list_checker.sv
// Checker for the handle list table: predicts each result word and compares it.
module hlt_list_checker
  import hlt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [1:0]             in_action,
  input  logic [IN_HANDLE_W-1:0] in_handle,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [1:0]             out_status,
  input  logic                   out_found,
  input  logic [POS_W-1:0]       out_position,
  input  logic [COUNT_W-1:0]     out_entry_count,
  output int                     mismatch_count,
  output int                     results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t              status;
    logic                 found;
    logic [POS_W-1:0]     position;
    logic [COUNT_W-1:0]   entry_count;
  } list_result_t;

  key_t         list_mem [CAPACITY];
  int           list_fill = 0;
  list_result_t awaited_results [$];
  int           result_index = 0;

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                result_index, name, got, want));
    end
  endtask

  // Apply one operation to the shadow list and return the word it yields.
  function automatic list_result_t predict_list_op(action_t act, key_t key);
    list_result_t res;
    int           hit_at;
    res    = '0;
    res.status = ST_OK;
    hit_at = -1;
    if (act == ACT_REMOVE || act == ACT_LOOKUP) begin
      for (int i = 0; i < list_fill; i++) begin
        if (hit_at < 0 && list_mem[i] == key) hit_at = i;
      end
      if (hit_at < 0) begin
        res.status = ST_MISSING;
      end else begin
        res.found    = 1'b1;
        res.position = hit_at[POS_W-1:0];
      end
    end
    case (act)
      ACT_ADD: begin
        if (list_fill >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_mem[list_fill] = key;
          list_fill++;
        end
      end
      ACT_REMOVE: begin
        if (hit_at >= 0) begin
          for (int j = hit_at; j + 1 < list_fill; j++) list_mem[j] = list_mem[j + 1];
          list_fill--;
          list_mem[list_fill] = '0;
        end
      end
      ACT_CLEAR: list_fill = 0;
      default: ;
    endcase
    res.entry_count = list_fill[COUNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      list_fill = 0;
      awaited_results.delete();
      results_owed <= 0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(predict_list_op(in_action, in_handle[KEY_W-1:0]));
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none awaited", result_index));
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", 32'(out_status), 32'(want.status));
          compare_field("found", 32'(out_found), 32'(want.found));
          compare_field("position", 32'(out_position), 32'(want.position));
          compare_field("entry_count", 32'(out_entry_count), 32'(want.entry_count));
        end
        result_index++;
      end
      results_owed <= awaited_results.size();
    end
  end

endmodule

// File: verif/tb_handle_list_table_unit.sv
// Top of the handle list table testbench: clock, reset, stimulus and verdict.
module tb_handle_list_table_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hlt_pkg::*;

  // Far above the slowest legal run: ~1800 words of the longest operation each,
  // plus sender gaps and receiver stalls.
  localparam int CYCLE_LIMIT  = 2_000_000;
  // Longest single operation (remove near a full list) plus some margin.
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
  localparam int PHASE_WORDS  = 600;
  localparam int FILL_BURST   = CAPACITY + 2;
  localparam int SEGMENT_LEN  = 150;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             in_action;
  logic [IN_HANDLE_W-1:0] in_handle;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             out_status;
  logic                   out_found;
  logic [POS_W-1:0]       out_position;
  logic [COUNT_W-1:0]     out_entry_count;

  int mismatch_count;
  int results_owed;
  int cycle_count = 0;

  // Percent of cycles each side holds off; changed per phase.
  int send_idle_pct = 16;
  int recv_idle_pct = 74;

  // Handles currently in the list as far as the stimulus knows; used only
  // to aim adds, removes and lookups at live entries, deep positions included.
  logic [31:0] stored_handles [$];

  handle_list_table_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_handle       (in_handle),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

  hlt_list_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_handle       (in_handle),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_position    (out_position),
    .out_entry_count (out_entry_count),
    .mismatch_count  (mismatch_count),
    .results_owed    (results_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: drop ready at random, decided at each falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Present one word and hold it until accepted. Gaps come before the word,
  // so valid never drops once raised.
  task automatic send_word(action_t act, logic [31:0] h);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_handle <= h;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every predicted result has been taken.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  // One random word. Mostly well-formed traffic aimed at live handles,
  // with a little noise of any action and any handle.
  task automatic random_word(int clear_pct, int add_pct);
    int          r;
    int          k;
    int          remove_pct;
    action_t     act;
    logic [31:0] h;
    r          = $urandom_range(99);
    remove_pct = (100 - clear_pct - add_pct) / 2;
    if (r < clear_pct) act = ACT_CLEAR;
    else if (r < clear_pct + add_pct) act = ACT_ADD;
    else if (r < clear_pct + add_pct + remove_pct) act = ACT_REMOVE;
    else act = ACT_LOOKUP;

    if (act == ACT_ADD) begin
      k = $urandom_range(99);
      if (k < 60 || stored_handles.size() == 0) h = $urandom();
      else if (k < 85) h = stored_handles[$urandom_range(stored_handles.size() - 1)];
      else h = (k % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
    end else if ($urandom_range(99) < 80 && stored_handles.size() != 0) begin
      h = stored_handles[$urandom_range(stored_handles.size() - 1)];
    end else begin
      h = $urandom();
    end

    // Noise: any action with any handle.
    if ($urandom_range(99) < 4) begin
      act = action_t'($urandom_range(3));
      h   = $urandom();
    end

    send_word(act, h);

    // Track the list the way the block should: append below capacity,
    // remove the first match, empty on clear.
    case (act)
      ACT_ADD: if (stored_handles.size() < CAPACITY) stored_handles.push_back(h);
      ACT_REMOVE: begin
        k = -1;
        foreach (stored_handles[i]) if (k < 0 && stored_handles[i] == h) k = i;
        if (k >= 0) stored_handles.delete(k);
      end
      ACT_CLEAR: stored_handles.delete();
      default: ;
    endcase
  endtask

  initial begin
    int n;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_action = ACT_ADD;
    in_handle = '0;
    out_ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, extreme handles, duplicates, first and last
    // entry removal, misses, and clear on a loaded and an empty list.
    send_word(ACT_LOOKUP, 32'h0000_0000);
    send_word(ACT_REMOVE, 32'h0000_0000);
    send_word(ACT_ADD,    32'h0000_0000);
    send_word(ACT_ADD,    32'hFFFF_FFFF);
    send_word(ACT_ADD,    32'h1234_5678);
    send_word(ACT_ADD,    32'h0000_0000);
    send_word(ACT_LOOKUP, 32'h0000_0000);
    send_word(ACT_LOOKUP, 32'hFFFF_FFFF);
    send_word(ACT_LOOKUP, 32'hDEAD_BEEF);
    send_word(ACT_REMOVE, 32'hDEAD_BEEF);
    send_word(ACT_REMOVE, 32'h0000_0000);
    send_word(ACT_LOOKUP, 32'h0000_0000);
    send_word(ACT_REMOVE, 32'h0000_0000);
    send_word(ACT_ADD,    32'hA5A5_A5A5);
    send_word(ACT_REMOVE, 32'hFFFF_FFFF);
    send_word(ACT_CLEAR,  32'h5A5A_5A5A);
    send_word(ACT_LOOKUP, 32'h1234_5678);
    send_word(ACT_ADD,    32'h5A5A_5A5A);
    send_word(ACT_CLEAR,  32'hFFFF_FFFF);
    send_word(ACT_CLEAR,  32'h0000_0000);

    // Three idling phases: sender light / receiver heavy, the reverse,
    // then no idling at all.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      // Pause until the block has delivered everything owed.
      drain_results();

      // Start each phase from a list filled past capacity, so adds hit a
      // full list and lookups and removes reach the top positions.
      random_word(100, 0);
      for (n = 1; n < FILL_BURST; n++) random_word(0, 100);

      // Alternate segments that grow the list toward full with segments
      // that churn it, clears included.
      for (n = FILL_BURST; n < PHASE_WORDS; n++) begin
        if ((n / SEGMENT_LEN) % 2 == 0) random_word(0, 58);
        else random_word(4, 45);
      end
    end

    // Wait for every result, then for the longest operation to settle.
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && results_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
